[hdl/graph_degree_statistics_unit_macros.svh]
// Assertion macros for the graph degree statistics unit.
// Used by the port-level checker; no other dependencies.
`ifndef GRAPH_DEGREE_STATISTICS_UNIT_MACROS_SVH
`define GRAPH_DEGREE_STATISTICS_UNIT_MACROS_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define GDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/gds_pkg.sv]
// Shared types, constants and helpers for the graph degree statistics unit.
// No dependencies.
`default_nettype none

package gds_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int DEGREE_BITS  = 9;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int VTX_W        = 6;
    localparam int LOOP_W       = 8;
    localparam int PAR_W        = 9;

    localparam logic [DEGREE_BITS-1:0] DEG_MAX    = '1;
    localparam logic [VTX_W-1:0]       VTX_LIMIT  = VTX_W'(MAX_VERTICES);
    localparam logic [VTX_W-1:0]       VC_RESET   = 6'd32;
    localparam logic [LOOP_W-1:0]      LOOP_MAX   = '1;
    localparam logic [PAR_W-1:0]       PAR_MAX    = '1;

    typedef struct packed {
        logic [VTX_W-1:0] first_vertex;
        logic [VTX_W-1:0] second_vertex;
        logic             last_edge;
    } gds_in_t;

    typedef struct packed {
        logic                   record_kind;
        logic [VTX_W-1:0]       vertex_number;
        logic [DEGREE_BITS-1:0] vertex_degree;
        logic                   vertex_isolated;
        logic [DEGREE_BITS-1:0] max_degree;
        logic [DEGREE_BITS-1:0] min_degree;
        logic                   is_regular;
        logic [LOOP_W-1:0]      loop_total;
        logic [PAR_W-1:0]       parallel_total;
        logic [VTX_W-1:0]       isolated_total;
        logic                   range_error;
        logic                   last_result;
    } gds_out_t;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_UPD_A = 8'b0000_0010,
        S_UPD_B = 8'b0000_0100,
        S_RD    = 8'b0000_1000,
        S_LOAD  = 8'b0001_0000,
        S_WAIT  = 8'b0010_0000,
        S_SUM   = 8'b0100_0000,
        S_SWAIT = 8'b1000_0000
    } gds_state_t;

    typedef struct packed {
        logic accept;       // edge beat taken, read both ends
        logic wr_a;         // write first end
        logic wr_b;         // write second end
        logic walk_rd;      // read vertex at walk index
        logic load_vertex;  // per-vertex record into output register
        logic walk_next;    // advance walk index
        logic load_sum;     // summary record into output register
        logic clear;        // wipe run state
    } gds_cmd_t;

    typedef struct packed {
        logic edge_ok;
        logic edge_loop;
        logic edge_last;
        logic walk_last;
        logic out_taken;
    } gds_sts_t;

    function automatic logic [DEGREE_BITS-1:0] sat_add(
        input logic [DEGREE_BITS-1:0] deg,
        input logic [1:0]             inc
    );
        logic [DEGREE_BITS:0] sum;
        sum = {1'b0, deg} + (DEGREE_BITS+1)'(inc);
        return sum[DEGREE_BITS] ? DEG_MAX : sum[DEGREE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/gds_ctrl.sv]
// Sequencing state machine for the graph degree statistics unit.
// Depends on gds_pkg; drives gds_dpath through a command struct.
`default_nettype none

module gds_ctrl
    import gds_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire gds_sts_t sts,
    output gds_cmd_t      cmd
);

    gds_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_UPD_A;
                end
            end
            S_UPD_A: begin
                cmd.wr_a = sts.edge_ok;
                priority if (sts.edge_ok && !sts.edge_loop) begin
                    state_next = S_UPD_B;
                end else if (sts.edge_last) begin
                    state_next = S_RD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_UPD_B: begin
                cmd.wr_b   = 1'b1;
                state_next = sts.edge_last ? S_RD : S_IDLE;
            end
            S_RD: begin
                cmd.walk_rd = 1'b1;
                state_next  = S_LOAD;
            end
            S_LOAD: begin
                cmd.load_vertex = 1'b1;
                state_next      = S_WAIT;
            end
            S_WAIT: begin
                if (sts.out_taken) begin
                    if (sts.walk_last) begin
                        state_next = S_SUM;
                    end else begin
                        cmd.walk_next = 1'b1;
                        state_next    = S_RD;
                    end
                end
            end
            S_SUM: begin
                cmd.load_sum = 1'b1;
                state_next   = S_SWAIT;
            end
            S_SWAIT: begin
                if (sts.out_taken) begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/gds_dpath.sv]
// Datapath: degree memory, run counters, walk statistics, output register.
// Depends on gds_pkg; steered by gds_ctrl.
`default_nettype none

module gds_dpath
    import gds_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [VTX_W-1:0] cfg_wr_data,
    input  wire gds_in_t    s_data,
    output gds_out_t        m_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire gds_cmd_t   cmd,
    output gds_sts_t        sts
);

    // configuration
    logic [VTX_W-1:0] vc_reg;
    logic [VTX_W-1:0] eff_n;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= VC_RESET;
        end else if (cfg_wr_en) begin
            vc_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        priority if (vc_reg == '0) begin
            eff_n = VTX_W'(1);
        end else if (vc_reg > VTX_LIMIT) begin
            eff_n = VTX_LIMIT;
        end else begin
            eff_n = vc_reg;
        end
    end

    // incoming edge decode
    logic [VTX_W-1:0] in_a, in_b, in_lo, in_hi, a_m1, b_m1;
    logic [IDX_W-1:0] a_idx_in, b_idx_in;
    logic             in_ok, in_loop;

    assign in_a     = s_data.first_vertex;
    assign in_b     = s_data.second_vertex;
    assign in_ok    = (in_a != '0) && (in_b != '0) && (in_a <= eff_n) && (in_b <= eff_n);
    assign in_loop  = (in_a == in_b);
    assign in_lo    = (in_a < in_b) ? in_a : in_b;
    assign in_hi    = (in_a < in_b) ? in_b : in_a;
    assign a_m1     = in_a - VTX_W'(1);
    assign b_m1     = in_b - VTX_W'(1);
    assign a_idx_in = a_m1[IDX_W-1:0];
    assign b_idx_in = b_m1[IDX_W-1:0];

    logic [IDX_W-1:0] a_idx_reg, b_idx_reg;
    logic             ok_reg, loop_reg, last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            a_idx_reg <= a_idx_in;
            b_idx_reg <= b_idx_in;
            ok_reg    <= in_ok;
            loop_reg  <= in_loop;
            last_reg  <= s_data.last_edge;
        end
    end

    // degree memory; entries not yet written read as zero
    logic [DEGREE_BITS-1:0]  deg_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] deg_vld_reg;
    logic [DEGREE_BITS-1:0]  rd_a_reg, rd_b_reg, deg_a, deg_b, wr_data;
    logic                    vld_a_reg, vld_b_reg, rd_en, wr_en;
    logic [IDX_W-1:0]        rd_addr_a, wr_addr;
    logic [IDX_W-1:0]        walk_idx_reg;

    assign rd_en     = cmd.accept | cmd.walk_rd;
    assign rd_addr_a = cmd.accept ? a_idx_in : walk_idx_reg;
    assign wr_en     = cmd.wr_a | cmd.wr_b;
    assign wr_addr   = cmd.wr_b ? b_idx_reg : a_idx_reg;
    assign deg_a     = vld_a_reg ? rd_a_reg : '0;
    assign deg_b     = vld_b_reg ? rd_b_reg : '0;
    assign wr_data   = cmd.wr_b ? sat_add(deg_b, 2'd1)
                                : sat_add(deg_a, loop_reg ? 2'd2 : 2'd1);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg  <= deg_mem[rd_addr_a];
            rd_b_reg  <= deg_mem[b_idx_in];
            vld_a_reg <= deg_vld_reg[rd_addr_a];
            vld_b_reg <= deg_vld_reg[b_idx_in];
        end
        if (wr_en) begin
            deg_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            deg_vld_reg <= '0;
        end else if (wr_en) begin
            deg_vld_reg[wr_addr] <= 1'b1;
        end
    end

    // run counters and previous-edge memory
    logic [LOOP_W-1:0] loop_cnt_reg;
    logic [PAR_W-1:0]  par_cnt_reg;
    logic [PAR_W:0]    par_sum;
    logic [VTX_W-1:0]  prev_lo_reg, prev_hi_reg;
    logic              prev_vld_reg, err_reg;

    assign par_sum = {1'b0, par_cnt_reg} + (PAR_W+1)'(2);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            loop_cnt_reg <= '0;
            par_cnt_reg  <= '0;
            prev_lo_reg  <= '0;
            prev_hi_reg  <= '0;
            prev_vld_reg <= 1'b0;
            err_reg      <= 1'b0;
        end else if (cmd.accept) begin
            priority if (!in_ok) begin
                err_reg <= 1'b1;
            end else if (in_loop) begin
                if (loop_cnt_reg != LOOP_MAX) begin
                    loop_cnt_reg <= loop_cnt_reg + LOOP_W'(1);
                end
                prev_vld_reg <= 1'b0;
            end else begin
                if (prev_vld_reg && prev_lo_reg == in_lo && prev_hi_reg == in_hi) begin
                    par_cnt_reg <= par_sum[PAR_W] ? PAR_MAX : par_sum[PAR_W-1:0];
                end
                prev_lo_reg  <= in_lo;
                prev_hi_reg  <= in_hi;
                prev_vld_reg <= 1'b1;
            end
        end
    end

    // walk statistics
    logic [DEGREE_BITS-1:0] max_reg, min_reg, first_reg;
    logic [VTX_W-1:0]       iso_reg, walk_num;
    logic                   reg_flag_reg, walk_first;

    assign walk_num   = VTX_W'(walk_idx_reg) + VTX_W'(1);
    assign walk_first = (walk_idx_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            walk_idx_reg <= '0;
            max_reg      <= '0;
            min_reg      <= DEG_MAX;
            iso_reg      <= '0;
            reg_flag_reg <= 1'b1;
        end else begin
            if (cmd.walk_next) begin
                walk_idx_reg <= walk_idx_reg + IDX_W'(1);
            end
            if (cmd.load_vertex) begin
                if (deg_a > max_reg) max_reg <= deg_a;
                if (deg_a < min_reg) min_reg <= deg_a;
                if (deg_a == '0)     iso_reg <= iso_reg + VTX_W'(1);
                if (!walk_first && deg_a != first_reg) reg_flag_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_vertex && walk_first) begin
            first_reg <= deg_a;
        end
    end

    // output register
    gds_out_t m_data_reg;
    logic     m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_vertex || cmd.load_sum) begin
            m_valid_reg <= 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_vertex) begin
            m_data_reg                 <= '0;
            m_data_reg.vertex_number   <= walk_num;
            m_data_reg.vertex_degree   <= deg_a;
            m_data_reg.vertex_isolated <= (deg_a == '0);
        end else if (cmd.load_sum) begin
            m_data_reg                <= '0;
            m_data_reg.record_kind    <= 1'b1;
            m_data_reg.max_degree     <= max_reg;
            m_data_reg.min_degree     <= min_reg;
            m_data_reg.is_regular     <= reg_flag_reg;
            m_data_reg.loop_total     <= loop_cnt_reg;
            m_data_reg.parallel_total <= par_cnt_reg;
            m_data_reg.isolated_total <= iso_reg;
            m_data_reg.range_error    <= err_reg;
            m_data_reg.last_result    <= 1'b1;
        end
    end

    assign m_data  = m_data_reg;
    assign m_valid = m_valid_reg;

    assign sts.edge_ok   = ok_reg;
    assign sts.edge_loop = loop_reg;
    assign sts.edge_last = last_reg;
    assign sts.walk_last = (walk_num == eff_n);
    assign sts.out_taken = m_valid_reg & m_ready;

endmodule

`default_nettype wire

[hdl/graph_degree_statistics_unit.sv]
// Flow: an edge beat passes IDLE and UPD_A (loop or out-of-range) or IDLE, UPD_A
//   and UPD_B (ordinary edge); one write port on the degree memory sets that split.
// On the last edge, each vertex record is read (RD) and loaded (LOAD) once the
//   previous one is taken, the summary loaded (SUM) once the last one is taken.
// Reset (aresetn low, synchronous) clears degrees, counters and vertex_count=32.
`default_nettype none

// Top level: graph degree statistics over an edge stream.
// Depends on gds_pkg, gds_ctrl and gds_dpath.
module graph_degree_statistics_unit
    import gds_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // configuration: vertex_count
    input  wire logic             cfg_wr_en,
    input  wire logic [VTX_W-1:0] cfg_wr_data,
    // edge beats
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire gds_in_t          s_data,
    // result beats
    output logic                  m_valid,
    input  wire logic             m_ready,
    output gds_out_t              m_data
);

    // Flow of one edge:
    //   IDLE   - beat taken, both endpoint degrees read from the memory,
    //            loop / parallel / range bookkeeping done in the same cycle.
    //   UPD_A  - first endpoint written back if in range (+2 for a loop, +1 otherwise).
    //   UPD_B  - second endpoint written back (ordinary edges only).
    // On a last edge the walk runs over vertices 1..n: read, load the output
    // register, wait for the sink, then the summary. Taking the summary
    // clears the run state (all valid bits of the degree memory at once).
    // s_ready is high only in IDLE, so no edge arrives while records drain.

    gds_cmd_t cmd;
    gds_sts_t sts;

    gds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gds_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_data      (m_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire

[hdl/gds_checker.sv]
// Port-level checker for graph_degree_statistics_unit, attached by bind.
// Depends on gds_pkg and graph_degree_statistics_unit_macros.svh.
`default_nettype none

`include "graph_degree_statistics_unit_macros.svh"

module gds_checker
    import gds_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire gds_out_t m_data
);

    // a stalled result beat holds
    `GDS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result beat dropped or changed while stalled")

    // edges are never taken while records drain
    `GDS_ASSERT_NOW(a_no_overlap, m_valid, !s_ready, "edge beat open while a result waits")

    // summary is the only record flagged last
    `GDS_ASSERT_NOW(a_kind_last, m_valid, m_data.record_kind == m_data.last_result, "record kind and last flag disagree")

    // taking the summary returns the block to accepting edges
    `GDS_ASSERT_NEXT(a_sum_done, m_valid && m_ready && m_data.last_result, s_ready && !m_valid, "block not idle after summary")

endmodule

bind graph_degree_statistics_unit gds_checker u_gds_checker (.*);

`default_nettype wire

[verif/graph_degree_statistics_unit_tb.sv]
// Self-checking testbench for graph_degree_statistics_unit: edge beats in, vertex and
// summary record beats out, checked against a built-in degree tracker.
// Depends on gds_pkg and the graph_degree_statistics_unit RTL.
module graph_degree_statistics_unit_tb;
    import gds_pkg::*;

    // The limit only catches a hang.
    localparam int CYCLE_LIMIT  = 400_000;
    // Edge beats with no last mark give no record, so the block may still be
    // busy after the last record arrives. Wait this long before a count write.
    localparam int SETTLE       = 12;
    // In-range random edges (noise beats don't count).
    localparam int RANDOM_EDGES = 180;

    // One row of the directed table. A typed row carries its summary record
    // by hand. The vertex records of that row come from the tracker.
    typedef struct packed {
        logic             set_cfg;
        logic [VTX_W-1:0] cfg;
        gds_in_t          beat;
        logic             typed;
        gds_out_t         summary;
    } dir_row_t;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [VTX_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    gds_in_t          s_data      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    gds_out_t         m_data;

    // Degree tracker: our own copy of the graph state and the vertex count.
    logic [DEGREE_BITS-1:0] deg_tbl [MAX_VERTICES];
    logic [LOOP_W-1:0]      loop_cnt;
    logic [PAR_W-1:0]       par_cnt;
    logic [VTX_W-1:0]       prev_lo;
    logic [VTX_W-1:0]       prev_hi;
    logic                   prev_ok;
    logic                   err_flag;
    logic [VTX_W-1:0]       vcount;

    gds_out_t    expected_records [$];
    dir_row_t    dir_rows [$];
    gds_out_t    want_rec;
    int          errors      = 0;
    int unsigned cycle_count = 0;
    // When set, neither side idles: gives back-to-back stretches.
    bit          no_idle     = 1'b0;

    graph_degree_statistics_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hang guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Tracker
    // ---------------------------------------------------------------------

    // A count of 0 acts as 1; anything above the store depth acts as full.
    function automatic int active_vertices();
        if (vcount == 0)
            return 1;
        if (vcount > MAX_VERTICES)
            return MAX_VERTICES;
        return vcount;
    endfunction

    function automatic int unsigned idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic clear_graph();
        for (int i = 0; i < MAX_VERTICES; i++)
            deg_tbl[i] = '0;
        loop_cnt = '0;
        par_cnt  = '0;
        prev_lo  = '0;
        prev_hi  = '0;
        prev_ok  = 1'b0;
        err_flag = 1'b0;
    endtask

    // Saturating degree bump.
    task automatic add_degree(input int v, input int inc);
        int s;
        s = deg_tbl[v] + inc;
        deg_tbl[v] = (s > DEG_MAX) ? DEG_MAX : s[DEGREE_BITS-1:0];
    endtask

    // Fold one accepted edge beat into the graph; on a last beat queue the
    // vertex records and the summary, then start a fresh graph.
    task automatic track_edge(input gds_in_t e);
        int       n, a, b, lo, hi, p, maxd, mind, iso;
        bit       flat;
        gds_out_t r;
        n = active_vertices();
        a = e.first_vertex;
        b = e.second_vertex;
        if (a == 0 || b == 0 || a > n || b > n) begin
            // bad vertex: edge dropped whole, adjacency memory kept
            err_flag = 1'b1;
        end else if (a == b) begin
            add_degree(a - 1, 2);
            if (loop_cnt != LOOP_MAX)
                loop_cnt = loop_cnt + 1'b1;
            prev_ok = 1'b0;     // a loop breaks the parallel chain
        end else begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            add_degree(a - 1, 1);
            add_degree(b - 1, 1);
            if (prev_ok && prev_lo == lo && prev_hi == hi) begin
                p = par_cnt + 2;
                par_cnt = (p > PAR_MAX) ? PAR_MAX : p[PAR_W-1:0];
            end
            prev_lo = lo[VTX_W-1:0];
            prev_hi = hi[VTX_W-1:0];
            prev_ok = 1'b1;
        end
        if (!e.last_edge)
            return;

        maxd = 0;
        mind = DEG_MAX;
        iso  = 0;
        flat = 1'b1;
        for (int i = 0; i < n; i++) begin
            r = '0;
            r.vertex_number   = VTX_W'(i + 1);
            r.vertex_degree   = deg_tbl[i];
            r.vertex_isolated = (deg_tbl[i] == 0);
            expected_records.push_back(r);
            if (deg_tbl[i] > maxd)
                maxd = deg_tbl[i];
            if (deg_tbl[i] < mind)
                mind = deg_tbl[i];
            if (deg_tbl[i] != deg_tbl[0])
                flat = 1'b0;
            if (deg_tbl[i] == 0)
                iso++;
        end
        r = '0;
        r.record_kind    = 1'b1;
        r.max_degree     = DEGREE_BITS'(maxd);
        r.min_degree     = DEGREE_BITS'(mind);
        r.is_regular     = flat;
        r.loop_total     = loop_cnt;
        r.parallel_total = par_cnt;
        r.isolated_total = VTX_W'(iso);
        r.range_error    = err_flag;
        r.last_result    = 1'b1;
        expected_records.push_back(r);
        clear_graph();
    endtask

    // ---------------------------------------------------------------------
    // Result side: random backpressure per beat, then check against the
    // oldest queued record.
    // ---------------------------------------------------------------------

    initial begin
        int unsigned gap;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            gap = idle_cycles();
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid)
                @(posedge aclk);
        end
    end

    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_records.size() == 0) begin
                $display("%0t: record beat expected none got %h", $time, m_data);
                errors++;
            end else begin
                want_rec = expected_records.pop_front();
                cmp_field("record_kind",     want_rec.record_kind,     m_data.record_kind);
                cmp_field("vertex_number",   want_rec.vertex_number,   m_data.vertex_number);
                cmp_field("vertex_degree",   want_rec.vertex_degree,   m_data.vertex_degree);
                cmp_field("vertex_isolated", want_rec.vertex_isolated,
                          m_data.vertex_isolated);
                cmp_field("max_degree",      want_rec.max_degree,      m_data.max_degree);
                cmp_field("min_degree",      want_rec.min_degree,      m_data.min_degree);
                cmp_field("is_regular",      want_rec.is_regular,      m_data.is_regular);
                cmp_field("loop_total",      want_rec.loop_total,      m_data.loop_total);
                cmp_field("parallel_total",  want_rec.parallel_total,
                          m_data.parallel_total);
                cmp_field("isolated_total",  want_rec.isolated_total,
                          m_data.isolated_total);
                cmp_field("range_error",     want_rec.range_error,     m_data.range_error);
                cmp_field("last_result",     want_rec.last_result,     m_data.last_result);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Edge side
    // ---------------------------------------------------------------------

    // Called at a clock edge. Valid is only lowered when a gap is drawn, so
    // back-to-back beats keep it high with no drop in between.
    task automatic put_edge(input gds_in_t e);
        int unsigned gap;
        gap = idle_cycles();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= e;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        track_edge(e);
    endtask

    // Stop sending until every queued record is back and the block is idle.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (expected_records.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_vertex_count(input logic [VTX_W-1:0] v);
        hold_until_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        vcount       = v;
    endtask

    function automatic gds_in_t mk_edge(input int a, input int b, input bit last);
        gds_in_t e;
        e.first_vertex  = VTX_W'(a);
        e.second_vertex = VTX_W'(b);
        e.last_edge     = last;
        return e;
    endfunction

    function automatic gds_out_t summary_of(input int maxd, input int mind, input bit flat,
                                            input int loops, input int par, input int iso,
                                            input bit err);
        gds_out_t r;
        r = '0;
        r.record_kind    = 1'b1;
        r.max_degree     = DEGREE_BITS'(maxd);
        r.min_degree     = DEGREE_BITS'(mind);
        r.is_regular     = flat;
        r.loop_total     = LOOP_W'(loops);
        r.parallel_total = PAR_W'(par);
        r.isolated_total = VTX_W'(iso);
        r.range_error    = err;
        r.last_result    = 1'b1;
        return r;
    endfunction

    function automatic dir_row_t mk_row(input bit set_cfg, input int cfg, input gds_in_t e,
                                        input bit typed, input gds_out_t s);
        dir_row_t row;
        row.set_cfg = set_cfg;
        row.cfg     = VTX_W'(cfg);
        row.beat    = e;
        row.typed   = typed;
        row.summary = s;
        return row;
    endfunction

    // Random vertex count: mostly small graphs, a few large ones, and now and
    // then a value the block must clamp.
    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(1, 8);
        if (r < 9)
            return $urandom_range(9, 32);
        return $urandom_range(0, 1) ? 0 : $urandom_range(33, 63);
    endfunction

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------

    initial begin
        gds_in_t e;
        int      n, len, pick, a, b, t, random_sent;
        bit      have_pair, noise;

        vcount = VC_RESET;
        clear_graph();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Summaries typed in where they are obvious.
        // Fresh out of reset, 32 vertices, bad beat that is also the last:
        // everything isolated, error flagged.
        dir_rows.push_back(mk_row(0, 0,  mk_edge(0, 0, 1),   1,
                                  summary_of(0, 0, 1, 0, 0, 32, 1)));
        // Three vertices: repeated pair, loop breaks the chain, then the pair
        // again without a parallel bump.
        dir_rows.push_back(mk_row(1, 3,  mk_edge(1, 2, 0),   0, '0));
        dir_rows.push_back(mk_row(0, 0,  mk_edge(2, 1, 0),   0, '0));
        dir_rows.push_back(mk_row(0, 0,  mk_edge(3, 3, 0),   0, '0));
        dir_rows.push_back(mk_row(0, 0,  mk_edge(1, 2, 1),   1,
                                  summary_of(3, 2, 0, 1, 2, 0, 0)));
        // Single vertex with one loop.
        dir_rows.push_back(mk_row(1, 1,  mk_edge(1, 1, 1),   1,
                                  summary_of(2, 2, 1, 1, 0, 0, 0)));
        // Count 0 acts as 1: vertex 2 is out of range.
        dir_rows.push_back(mk_row(1, 0,  mk_edge(1, 1, 0),   0, '0));
        dir_rows.push_back(mk_row(0, 0,  mk_edge(2, 1, 1),   1,
                                  summary_of(2, 2, 1, 1, 0, 0, 1)));
        // Count 63 clamps to 32: top vertex works, 33 and 63 don't, and a bad
        // beat between two matching edges leaves the pair memory alone.
        dir_rows.push_back(mk_row(1, 63, mk_edge(32, 32, 0), 0, '0));
        dir_rows.push_back(mk_row(0, 0,  mk_edge(33, 1, 0),  0, '0));
        dir_rows.push_back(mk_row(0, 0,  mk_edge(63, 63, 0), 0, '0));
        dir_rows.push_back(mk_row(0, 0,  mk_edge(32, 1, 0),  0, '0));
        dir_rows.push_back(mk_row(0, 0,  mk_edge(0, 5, 0),   0, '0));
        dir_rows.push_back(mk_row(0, 0,  mk_edge(1, 32, 0),  0, '0));
        dir_rows.push_back(mk_row(0, 0,  mk_edge(40, 3, 1),  1,
                                  summary_of(4, 0, 0, 1, 2, 30, 1)));
        // Two vertices, a chain of three matching edges, closed by a loop.
        dir_rows.push_back(mk_row(1, 2,  mk_edge(1, 2, 0),   0, '0));
        dir_rows.push_back(mk_row(0, 0,  mk_edge(2, 1, 0),   0, '0));
        dir_rows.push_back(mk_row(0, 0,  mk_edge(1, 2, 0),   0, '0));
        dir_rows.push_back(mk_row(0, 0,  mk_edge(2, 2, 1),   0, '0));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_cfg)
                set_vertex_count(dir_rows[i].cfg);
            put_edge(dir_rows[i].beat);
            if (dir_rows[i].typed)
                expected_records[expected_records.size() - 1] = dir_rows[i].summary;
        end

        // Random graphs. Mostly well-formed edges with plenty of repeats and
        // loops, some out-of-range noise, count changes between graphs.
        random_sent = 0;
        while (random_sent < RANDOM_EDGES) begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                set_vertex_count(VTX_W'(pick_count()));
            else if (pick == 3)
                hold_until_drained();
            no_idle   = ($urandom_range(0, 4) == 0);
            n         = active_vertices();
            len       = $urandom_range(1, 12);
            have_pair = 1'b0;
            a         = 1;
            b         = 1;
            for (int k = 0; k < len; k++) begin
                pick  = $urandom_range(0, 99);
                noise = 1'b0;
                if (pick < 35 && have_pair) begin
                    // same pair again, either orientation
                    if ($urandom_range(0, 1)) begin
                        t = a;
                        a = b;
                        b = t;
                    end
                end else if (pick < 55) begin
                    a = $urandom_range(1, n);
                    b = a;
                end else if (pick < 88) begin
                    a = $urandom_range(1, n);
                    b = $urandom_range(1, n);
                    have_pair = (a != b);
                end else begin
                    // one end out of range; keep the last good pair around
                    noise = 1'b1;
                end
                if (noise) begin
                    t = $urandom_range(0, 1) ? 0 : $urandom_range(n + 1, 63);
                    if ($urandom_range(0, 1))
                        e = mk_edge(t, $urandom_range(0, 63), k == len - 1);
                    else
                        e = mk_edge($urandom_range(0, 63), t, k == len - 1);
                end else begin
                    e = mk_edge(a, b, k == len - 1);
                    random_sent++;
                end
                put_edge(e);
            end
        end

        // Let every record come back, then some margin.
        s_valid <= 1'b0;
        while (expected_records.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[graph_degree_statistics_unit.f]
+incdir+hdl
hdl/gds_pkg.sv
hdl/gds_ctrl.sv
hdl/gds_dpath.sv
hdl/graph_degree_statistics_unit.sv
hdl/gds_checker.sv
verif/graph_degree_statistics_unit_tb.sv
